// ----- hw/rtl/rrle_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// rrle_pkg
// Shared types and codes for the raster rectangle and line engine.
// ---------------------------------------------------------------------------
package rrle_pkg;

    typedef enum logic [2:0] {
        OP_FILL   = 3'd0,
        OP_STROKE = 3'd1,
        OP_LINE   = 3'd2,
        OP_SET    = 3'd3,
        OP_GET    = 3'd4
    } t_op;

    localparam logic [1:0] REG_WIDTH = 2'd0;
    localparam logic [1:0] REG_ROWS  = 2'd1;
    localparam logic [1:0] REG_COLOR = 2'd2;

    // rectangle request handed to the span walker
    typedef struct packed {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] w;
        logic signed [19:0] h;
    } t_rect;

endpackage : rrle_pkg
`default_nettype wire

// ----- hw/rtl/raster_rect_and_line_engine_unit.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// raster_rect_and_line_engine_unit
// Framebuffer drawing engine: clipped fill, stroke, bresenham line, pixel io.
// ---------------------------------------------------------------------------
// channel     | direction | content
// s_axis      | in        | one command
// m_axis      | out       | one result per command
// cfg         | in        | register index and value
//
// one pixel per cycle through a single address unit and one ram port.
// fill: a setup step plus the clipped w*h pixels; stroke: up to five fills in sequence;
// line: max(|dx|,|dy|)+1 pixels; set/get: at most one pixel write or one registered read.
// after reset a clearing pass zeroes all MAX_WIDTH*MAX_ROWS ram words before the
// first command is taken; a stalled result holds the engine.
// ---------------------------------------------------------------------------
module raster_rect_and_line_engine_unit
    import rrle_pkg::*;
#(
    parameter int MAX_WIDTH = 128,
    parameter int MAX_ROWS  = 128
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // op[2:0] pos_x[18:3] pos_y[34:19] ext_x[50:35] ext_y[66:51]
    // stroke_width[74:67] pixel_in[82:75]
    input  wire  [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // pixel_out[7:0] ok[8]
    output logic [15:0] m_axis_tdata,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [7:0]  i_cfg_data
);
    localparam int DEPTH = MAX_WIDTH * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISP, S_RSETUP, S_RUN, S_LSTEP, S_PIX, S_READ,
        S_READ2, S_OUT
    } t_state;

    function automatic logic on_c_start(input logic signed [19:0] x,
                                        input logic signed [19:0] y,
                                        input logic signed [19:0] w,
                                        input logic signed [19:0] h);
        return x >= 0 && y >= 0 && x < w && y < h;
    endfunction

    t_state            r_state;
    logic [7:0]        r_cw, r_cr, r_col;
    logic [AW-1:0]     r_clr;
    t_op               r_op;
    logic signed [19:0] r_px, r_py, r_ex, r_ey, r_t;
    logic [7:0]        r_pin, r_pout;
    logic              r_ok;
    logic [2:0]        r_phase;   // stroke part counter
    // walker
    logic signed [19:0] r_x, r_y, r_x0, r_xe, r_ye;
    // line
    logic signed [19:0] r_dx, r_dy, r_e, r_ux, r_uy, r_x2, r_y2;
    logic              r_xmaj;

    logic signed [19:0] aw, ar;
    assign aw = (r_cw == 8'd0) ? 20'sd1 :
                ({12'd0, r_cw} > 20'(MAX_WIDTH)) ? 20'(MAX_WIDTH) : {12'd0, r_cw};
    assign ar = (r_cr == 8'd0) ? 20'sd1 :
                ({12'd0, r_cr} > 20'(MAX_ROWS)) ? 20'(MAX_ROWS) : {12'd0, r_cr};

    // current rectangle: the request itself, or the current part of the stroke sequence
    t_rect rc;
    always_comb begin
        rc = '{x: r_px, y: r_py, w: r_ex, h: r_ey};
        unique case (r_phase)
            3'd0: rc = '{x: r_px, y: r_py, w: r_ex, h: r_ey};
            3'd1: rc = '{x: r_px, y: r_py, w: r_ex, h: r_t};
            3'd2: rc = '{x: r_px, y: r_py + r_ey - r_t, w: r_ex, h: r_t};
            3'd3: rc = '{x: r_px, y: r_py + r_t, w: r_t, h: r_ey - (r_t <<< 1)};
            3'd4: rc = '{x: r_px + r_ex - r_t, y: r_py + r_t, w: r_t,
                         h: r_ey - (r_t <<< 1)};
            default: rc = '{x: r_px, y: r_py, w: r_ex, h: r_ey};
        endcase
    end
    logic signed [19:0] cx, cy, cex, cey;
    always_comb begin
        cx  = (rc.x < 0) ? 20'sd0 : rc.x;
        cy  = (rc.y < 0) ? 20'sd0 : rc.y;
        cex = (cx + rc.w > aw) ? aw : cx + rc.w;
        cey = (cy + rc.h > ar) ? ar : cy + rc.h;
    end
    logic rect_on, rect_draw;
    assign rect_on   = (cx < aw) && (cy < ar);
    assign rect_draw = rect_on && rc.w > 0 && rc.h > 0;

    // shared address unit
    logic signed [19:0] ax, ay;
    logic               on_c;
    logic [AW+1:0]      addr_full;
    logic [21:0]        addr_lin;
    always_comb begin
        ax = r_x;
        ay = r_y;
        if (r_state == S_PIX || r_state == S_READ) begin
            ax = r_px;
            ay = r_py;
        end
    end
    assign on_c      = ax >= 0 && ay >= 0 && ax < aw && ay < ar;
    assign addr_lin  = {11'd0, ay[10:0]} * {11'd0, aw[10:0]} + {11'd0, ax[10:0]};
    assign addr_full = addr_lin[AW+1:0];

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wd, ram_rd;
    always_comb begin
        ram_we   = 1'b0;
        ram_addr = addr_full[AW-1:0];
        ram_wd   = r_col;
        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1; ram_addr = r_clr; ram_wd = 8'd0;
            end
            S_RUN, S_LSTEP: ram_we = on_c && addr_full < (AW+2)'(DEPTH);
            S_PIX: begin
                ram_we = (r_op == OP_SET) && on_c; ram_wd = r_pin;
            end
            default: ram_we = 1'b0;
        endcase
    end

    rrle_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wd),
        .o_rdata(ram_rd)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {7'd0, r_ok, r_pout};

    logic signed [19:0] ldx, ldy, e2;
    assign ldx = r_ex - r_px;
    assign ldy = r_ey - r_py;
    assign e2  = (r_e + (r_xmaj ? r_dy : r_dx)) <<< 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cw    <= 8'd128;
            r_cr    <= 8'd128;
            r_col   <= 8'd0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_WIDTH: r_cw  <= i_cfg_data;
                    REG_ROWS:  r_cr  <= i_cfg_data;
                    REG_COLOR: r_col <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (s_axis_tvalid) begin
                    r_op    <= t_op'(s_axis_tdata[2:0]);
                    r_px    <= 20'(signed'(s_axis_tdata[18:3]));
                    r_py    <= 20'(signed'(s_axis_tdata[34:19]));
                    r_ex    <= 20'(signed'(s_axis_tdata[50:35]));
                    r_ey    <= 20'(signed'(s_axis_tdata[66:51]));
                    r_t     <= {12'd0, s_axis_tdata[74:67]};
                    r_pin   <= s_axis_tdata[82:75];
                    r_pout  <= 8'd0;
                    r_ok    <= 1'b0;
                    r_phase <= 3'd0;
                    r_state <= S_DISP;
                end
                S_DISP: begin
                    unique case (r_op)
                        OP_FILL: begin
                            r_ok <= rect_on; r_state <= S_RSETUP;
                        end
                        OP_STROKE: begin
                            r_ok <= rect_on;
                            // whole fill only if thick; else skip to edges
                            if (!(r_t >= (r_ex / 2) || r_t >= (r_ey / 2)))
                                r_phase <= 3'd1;
                            r_state <= S_RSETUP;
                        end
                        OP_LINE: begin
                            r_ok   <= on_c_start(r_px, r_py, aw, ar);
                            r_x    <= r_px; r_y <= r_py;
                            r_x2   <= r_ex; r_y2 <= r_ey;
                            r_ux   <= (ldx > 0) ? 20'sd1 : -20'sd1;
                            r_uy   <= (ldy > 0) ? 20'sd1 : -20'sd1;
                            r_dx   <= (ldx < 0) ? -ldx : ldx;
                            r_dy   <= (ldy < 0) ? -ldy : ldy;
                            r_xmaj <= ((ldx < 0) ? -ldx : ldx) > ((ldy < 0) ? -ldy : ldy);
                            r_e    <= '0;
                            r_state <= S_LSTEP;
                        end
                        OP_SET, OP_GET: begin
                            r_ok <= on_c_start(r_px, r_py, aw, ar);
                            r_state <= (r_op == OP_SET) ? S_PIX : S_READ;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_RSETUP: begin
                    if (rect_draw) begin
                        r_x <= cx; r_y <= cy; r_x0 <= cx;
                        r_xe <= cex; r_ye <= cey;
                        r_state <= S_RUN;
                    end else if (r_op == OP_STROKE && r_phase != 3'd4) begin
                        r_phase <= r_phase + 3'd1;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_RUN: begin
                    if (r_x + 20'sd1 < r_xe) begin
                        r_x <= r_x + 20'sd1;
                    end else if (r_y + 20'sd1 < r_ye) begin
                        r_x <= r_x0; r_y <= r_y + 20'sd1;
                    end else if (r_op == OP_STROKE && r_phase != 3'd4) begin
                        r_phase <= r_phase + 3'd1; r_state <= S_RSETUP;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_LSTEP: begin
                    if (r_xmaj ? (r_x == r_x2) : (r_y == r_y2)) begin
                        r_state <= S_OUT;
                    end else if (r_xmaj) begin
                        if (e2 >= r_dx) begin
                            r_y <= r_y + r_uy; r_e <= r_e + r_dy - r_dx;
                        end else begin
                            r_e <= r_e + r_dy;
                        end
                        r_x <= r_x + r_ux;
                    end else begin
                        if (e2 >= r_dy) begin
                            r_x <= r_x + r_ux; r_e <= r_e + r_dx - r_dy;
                        end else begin
                            r_e <= r_e + r_dx;
                        end
                        r_y <= r_y + r_uy;
                    end
                end
                S_PIX:   r_state <= S_OUT;
                S_READ:  r_state <= S_READ2;
                S_READ2: begin
                    r_pout  <= r_ok ? ram_rd : 8'd0;
                    r_state <= S_OUT;
                end
                S_OUT: if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/rrle_ram.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// rrle_ram
// Generic single-port RAM with registered read.
// ---------------------------------------------------------------------------
module rrle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_addr,
    input  wire  [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire
